[rtl/triac_phase_angle_controller_assert.svh]
// Assertion macros for the triac phase-angle controller RTL.
// Included by the files that check internal invariants; needs clk and rst in scope.
`ifndef TRIAC_PHASE_ANGLE_CONTROLLER_ASSERT_SVH
`define TRIAC_PHASE_ANGLE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define TPAC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define TPAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tpac_pkg.sv]
// Shared types, constants and the cosine table of the triac phase-angle controller.
// No dependencies; used by the interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package tpac_pkg;

  // Field widths of the command and result words.
  localparam int CMD_W      = 3;
  localparam int CH_W       = 2;
  localparam int PCT_W      = 8;
  localparam int PWR_W      = 7;
  localparam int DLY_W      = 14;
  localparam int PHASE_W    = 14;
  localparam int WATTS_W    = 16;
  localparam int GATE_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int COUNT_W    = 3;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ZERO_CROSS = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_ALL    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_ONE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EN_ALL     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_EN_ONE     = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAINS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WATTS = 2'd2;

  // Timing constants in microsecond ticks, and the full and half power levels in percent.
  localparam logic [DLY_W-1:0]   HALF_60HZ  = 14'd8333;
  localparam logic [DLY_W-1:0]   HALF_50HZ  = 14'd10000;
  localparam logic [DLY_W-1:0]   MIN_DELAY  = 14'd100;
  localparam logic [PHASE_W-1:0] PHASE_MAX  = 14'h3FFF;
  localparam logic [PWR_W-1:0]   FULL_POWER = 7'd100;
  localparam logic [PWR_W-1:0]   HALF_POWER = 7'd50;

  // Firing ratio (1 + cos) / 2 in unsigned Q16, times the half cycle.
  localparam int               RATIO_W   = 17;
  localparam int               PROD_W    = RATIO_W + DLY_W;
  localparam int               PROD_SH   = 16;
  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd32768;

  // Division by 100 through reciprocals: max_watts = 100 * q + r.
  localparam int               QW_W         = 10;
  localparam int               RW_W         = 7;
  localparam int               WQ_PROD_W    = 33;
  localparam logic [16:0]      RECIP_100_W  = 17'd83887;
  localparam int               RECIP_W_SH   = 23;
  localparam int               PQ_W         = 16;
  localparam int               PR_W         = 14;
  localparam int               PR_PROD_W    = 28;
  localparam logic [PR_W-1:0]  RECIP_100_S  = 14'd10486;
  localparam int               RECIP_S_SH   = 20;
  localparam logic [WATTS_W-1:0] HUNDRED    = 16'd100;

  // Control word from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic load;
    logic calc;
    logic apply;
    logic w_init;
    logic w_rem;
    logic w_mul;
    logic w_acc;
    logic div_init;
    logic div_step;
    logic out_load;
  } tpac_cmd_t;

  // Status word from the datapath to the controller.
  typedef struct packed {
    logic needs_watts;
    logic last_chan;
    logic div_last;
    logic out_free;
  } tpac_sts_t;

  // Cosine in Q15 for k * pi / 100, k from 0 to 50.
  function automatic logic [15:0] cos_q15(input logic [5:0] k);
    logic [15:0] c;
    unique case (k)
      6'd0:  c = 16'd32768; 6'd1:  c = 16'd32752; 6'd2:  c = 16'd32703;
      6'd3:  c = 16'd32623; 6'd4:  c = 16'd32510; 6'd5:  c = 16'd32365;
      6'd6:  c = 16'd32188; 6'd7:  c = 16'd31979; 6'd8:  c = 16'd31739;
      6'd9:  c = 16'd31467; 6'd10: c = 16'd31164; 6'd11: c = 16'd30831;
      6'd12: c = 16'd30467; 6'd13: c = 16'd30073; 6'd14: c = 16'd29649;
      6'd15: c = 16'd29197; 6'd16: c = 16'd28715; 6'd17: c = 16'd28205;
      6'd18: c = 16'd27667; 6'd19: c = 16'd27102; 6'd20: c = 16'd26510;
      6'd21: c = 16'd25892; 6'd22: c = 16'd25248; 6'd23: c = 16'd24580;
      6'd24: c = 16'd23887; 6'd25: c = 16'd23170; 6'd26: c = 16'd22431;
      6'd27: c = 16'd21670; 6'd28: c = 16'd20887; 6'd29: c = 16'd20084;
      6'd30: c = 16'd19261; 6'd31: c = 16'd18418; 6'd32: c = 16'd17558;
      6'd33: c = 16'd16680; 6'd34: c = 16'd15786; 6'd35: c = 16'd14876;
      6'd36: c = 16'd13952; 6'd37: c = 16'd13014; 6'd38: c = 16'd12063;
      6'd39: c = 16'd11100; 6'd40: c = 16'd10126; 6'd41: c = 16'd9142;
      6'd42: c = 16'd8149;  6'd43: c = 16'd7148;  6'd44: c = 16'd6140;
      6'd45: c = 16'd5126;  6'd46: c = 16'd4107;  6'd47: c = 16'd3084;
      6'd48: c = 16'd2058;  6'd49: c = 16'd1029;
      default: c = 16'd0;
    endcase
    return c;
  endfunction

endpackage

[rtl/tpac_in_if.sv]
// Command channel of the triac phase-angle controller: valid, ready and one command word.
// Depends on tpac_pkg for the field widths.
`timescale 1ns / 1ps

interface tpac_in_if import tpac_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [CH_W-1:0]  channel;
  logic [PCT_W-1:0] power_req;
  logic             enable_bit;

  modport source (output valid, output cmd, output channel, output power_req,
                  output enable_bit, input ready);
  modport sink   (input valid, input cmd, input channel, input power_req,
                  input enable_bit, output ready);
endinterface

[rtl/tpac_out_if.sv]
// Result channel of the triac phase-angle controller: valid, ready and one result word.
// Depends on tpac_pkg for the field widths.
`timescale 1ns / 1ps

interface tpac_out_if import tpac_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [GATE_W-1:0]  gate_bits;
  logic               status;
  logic [PWR_W-1:0]   channel_power;
  logic               any_enabled;
  logic [WATTS_W-1:0] actual_watts;

  modport source (output valid, output gate_bits, output status, output channel_power,
                  output any_enabled, output actual_watts, input ready);
  modport sink   (input valid, input gate_bits, input status, input channel_power,
                  input any_enabled, input actual_watts, output ready);
endinterface

[rtl/tpac_ctrl.sv]
// Sequencing state machine of the triac phase-angle controller.
// Depends on tpac_pkg for the control and status words.
`timescale 1ns / 1ps

module tpac_ctrl import tpac_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  tpac_sts_t sts,
  output tpac_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CALC  = 4'd1;
  localparam logic [3:0] S_APPLY = 4'd2;
  localparam logic [3:0] S_WQ    = 4'd3;
  localparam logic [3:0] S_WR    = 4'd4;
  localparam logic [3:0] S_CHA   = 4'd5;
  localparam logic [3:0] S_CHB   = 4'd6;
  localparam logic [3:0] S_DINIT = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command decode and next state; no word is taken while reset is held.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = !rst;
        if (item_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = sts.needs_watts ? S_WQ : S_OUT;
      end
      S_WQ: begin
        cmd.w_init = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.w_rem  = 1'b1;
        state_next = S_CHA;
      end
      S_CHA: begin
        cmd.w_mul  = 1'b1;
        state_next = S_CHB;
      end
      S_CHB: begin
        cmd.w_acc  = 1'b1;
        state_next = sts.last_chan ? S_DINIT : S_CHA;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = sts.div_last ? S_OUT : S_DIV;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/tpac_dp.sv]
// Datapath of the triac phase-angle controller: channel state, delay and watts arithmetic.
// Depends on tpac_pkg, the channel interfaces and the assertion macro header.
`timescale 1ns / 1ps
`include "triac_phase_angle_controller_assert.svh"

module tpac_dp import tpac_pkg::*; #(
  parameter int CHANNELS    = 4,
  parameter int PULSE_TICKS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  tpac_cmd_t             cmd,
  output tpac_sts_t             sts,
  tpac_in_if.sink               item,
  tpac_out_if.source            result
);

  localparam int N_W     = $clog2(CHANNELS + 1);
  localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ACC_W   = WATTS_W + $clog2(CHANNELS);
  localparam int CNT_W   = $clog2(ACC_W);
  localparam int GATE_CH = (CHANNELS < GATE_W) ? CHANNELS : GATE_W;
  localparam int SNAP_W  = CHANNELS * PWR_W;

  // Configuration registers.
  logic               mains_is_60hz;
  logic [COUNT_W-1:0] channel_count;
  logic [WATTS_W-1:0] max_watts;
  logic               dirty;

  // Latched command word.
  logic [CMD_W-1:0] op_q;
  logic [CH_W-1:0]  ch_q;
  logic [PWR_W-1:0] pct_q;
  logic             en_q;

  // Channel state.
  logic [PWR_W-1:0]   chan_level [CHANNELS];
  logic [DLY_W-1:0]   fire_delay [CHANNELS];
  logic [CHANNELS-1:0] channel_enabled;
  logic [PHASE_W-1:0] phase_count;

  // Delay arithmetic.
  logic [PROD_W-1:0]  prod_q;
  logic [5:0]         cos_idx;
  logic [15:0]        cos_val;
  logic [RATIO_W-1:0] ratio;
  logic [DLY_W-1:0]   half;
  logic [DLY_W-1:0]   new_delay;

  // Watts arithmetic.
  logic [QW_W-1:0]      q_w;
  logic [RW_W-1:0]      r_w;
  logic [SNAP_W-1:0]    snap;
  logic [SNAP_W-1:0]    snap_init;
  logic [PQ_W-1:0]      pq;
  logic [PR_W-1:0]      pr;
  logic [ACC_W-1:0]     acc;
  logic [IDX_W-1:0]     idx;
  logic [WQ_PROD_W-1:0] wq_prod;
  logic [WATTS_W-1:0]   q_times_100;
  logic [WATTS_W-1:0]   rem_full;
  logic [PR_PROD_W-1:0] pr_prod;
  logic [WATTS_W-1:0]   watts;

  // Restoring divider by the channel count.
  logic [ACC_W-1:0] div_sh;
  logic [N_W-1:0]   rem;
  logic [CNT_W-1:0] div_cnt;
  logic [N_W:0]     rem_sh;
  logic [N_W:0]     rem_sub;
  logic             div_ge;
  logic [ACC_W-1:0] quot_next;

  // Channel selection and result fields.
  logic [N_W-1:0]      n_eff;
  logic [CHANNELS-1:0] in_use;
  logic [CHANNELS-1:0] ch_match;
  logic                ch_valid;
  logic [PWR_W-1:0]    power_sel;
  logic [GATE_W-1:0]   gate_next;
  logic                out_valid;

  // Effective channel count and per-channel decode.
  assign n_eff = (4'(channel_count) > 4'(CHANNELS)) ? N_W'(CHANNELS) : N_W'(channel_count);
  assign ch_valid = 4'(ch_q) < 4'(n_eff);

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      in_use[i]   = 4'(i) < 4'(n_eff);
      ch_match[i] = 4'(ch_q) == 4'(i);
    end
  end

  // Firing delay: table lookup and ratio times half cycle.
  assign half    = mains_is_60hz ? HALF_60HZ : HALF_50HZ;
  assign cos_idx = (pct_q <= HALF_POWER) ? pct_q[5:0] : 6'(FULL_POWER - pct_q);
  assign cos_val = cos_q15(cos_idx);
  assign ratio   = (pct_q <= HALF_POWER) ? (RATIO_ONE + RATIO_W'(cos_val))
                                         : (RATIO_ONE - RATIO_W'(cos_val));

  always_comb begin
    if (pct_q == '0) begin
      new_delay = half;
    end else if (pct_q == FULL_POWER) begin
      new_delay = MIN_DELAY;
    end else begin
      new_delay = prod_q[PROD_SH +: DLY_W];
    end
  end

  // Split max_watts into quotient and remainder by 100.
  assign wq_prod     = WQ_PROD_W'(max_watts) * WQ_PROD_W'(RECIP_100_W);
  assign q_times_100 = WATTS_W'(q_w) * HUNDRED;
  assign rem_full    = max_watts - q_times_100;
  assign pr_prod     = PR_PROD_W'(pr) * PR_PROD_W'(RECIP_100_S);

  // Snapshot of the power of enabled channels in use.
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      snap_init[i*PWR_W +: PWR_W] = (in_use[i] && channel_enabled[i]) ? chan_level[i] : '0;
    end
  end

  // One quotient bit of the restoring divider.
  assign rem_sh    = {rem, div_sh[ACC_W-1]};
  assign div_ge    = rem_sh >= (N_W+1)'(n_eff);
  assign rem_sub   = div_ge ? (rem_sh - (N_W+1)'(n_eff)) : rem_sh;
  assign quot_next = {div_sh[ACC_W-2:0], div_ge};

  // Result fields, taken after the command has been applied.
  always_comb begin
    power_sel = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (ch_match[i]) begin
        power_sel = chan_level[i];
      end
    end
  end

  always_comb begin
    gate_next = '0;
    for (int i = 0; i < GATE_CH; i++) begin
      gate_next[i] = in_use[i] && channel_enabled[i] && (chan_level[i] != '0) &&
                     (phase_count >= fire_delay[i]) &&
                     ({1'b0, phase_count} <
                      ({1'b0, fire_delay[i]} + (DLY_W+1)'(PULSE_TICKS)));
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mains_is_60hz   <= 1'b0;
      channel_count   <= 3'd1;
      max_watts       <= '0;
      dirty           <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_level[i] <= '0;
        fire_delay[i] <= HALF_50HZ;
      end
      channel_enabled <= '0;
      phase_count     <= PHASE_MAX;
      watts           <= '0;
      out_valid       <= 1'b0;
    end else begin
      // Register writes; any write forces a fresh watts estimate.
      if (cfg_write) begin
        dirty <= 1'b1;
        unique case (cfg_index)
          REG_MAINS:     mains_is_60hz <= cfg_data[0];
          REG_COUNT:     channel_count <= cfg_data[COUNT_W-1:0];
          REG_MAX_WATTS: max_watts     <= cfg_data;
          default: ;
        endcase
      end else if (cmd.w_init) begin
        dirty <= 1'b0;
      end

      // Apply the latched command.
      if (cmd.apply) begin
        unique case (op_q)
          CMD_TICK: begin
            if (phase_count != PHASE_MAX) begin
              phase_count <= phase_count + 1'b1;
            end
          end
          CMD_ZERO_CROSS: begin
            phase_count <= '0;
          end
          CMD_SET_ALL, CMD_SET_ONE: begin
            for (int i = 0; i < CHANNELS; i++) begin
              if ((op_q == CMD_SET_ALL) ? in_use[i] : (ch_valid && ch_match[i])) begin
                chan_level[i]      <= pct_q;
                fire_delay[i]      <= new_delay;
                channel_enabled[i] <= pct_q != '0;
              end
            end
          end
          CMD_EN_ALL, CMD_EN_ONE: begin
            for (int i = 0; i < CHANNELS; i++) begin
              if ((op_q == CMD_EN_ALL) ? in_use[i] : (ch_valid && ch_match[i])) begin
                channel_enabled[i] <= en_q && (chan_level[i] != '0);
              end
            end
          end
          default: ;
        endcase
      end

      // Last divider step writes the watts estimate.
      if (cmd.div_step && (div_cnt == '0)) begin
        watts <= (n_eff == '0) ? '0 : quot_next[WATTS_W-1:0];
      end

      // Result register handshake.
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the command, arithmetic and result words.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= item.cmd;
      ch_q  <= item.channel;
      pct_q <= (item.power_req > PCT_W'(FULL_POWER)) ? FULL_POWER
                                                     : item.power_req[PWR_W-1:0];
      en_q  <= item.enable_bit;
    end
    if (cmd.calc) begin
      prod_q <= PROD_W'(ratio) * PROD_W'(half);
    end
    if (cmd.w_init) begin
      q_w  <= wq_prod[RECIP_W_SH +: QW_W];
      snap <= snap_init;
      acc  <= '0;
      idx  <= '0;
    end
    if (cmd.w_rem) begin
      r_w <= rem_full[RW_W-1:0];
    end
    if (cmd.w_mul) begin
      pq   <= PQ_W'(snap[PWR_W-1:0]) * PQ_W'(q_w);
      pr   <= PR_W'(snap[PWR_W-1:0]) * PR_W'(r_w);
      snap <= snap >> PWR_W;
    end
    if (cmd.w_acc) begin
      acc <= acc + ACC_W'(pq) + ACC_W'(pr_prod[PR_PROD_W-1:RECIP_S_SH]);
      idx <= idx + 1'b1;
    end
    if (cmd.div_init) begin
      div_sh  <= acc;
      rem     <= '0;
      div_cnt <= CNT_W'(ACC_W - 1);
    end
    if (cmd.div_step) begin
      div_sh  <= quot_next;
      rem     <= rem_sub[N_W-1:0];
      div_cnt <= div_cnt - 1'b1;
    end
    if (cmd.out_load) begin
      result.gate_bits     <= gate_next;
      result.status        <= !ch_valid;
      result.channel_power <= ch_valid ? power_sel : '0;
      result.any_enabled   <= |(channel_enabled & in_use);
      result.actual_watts  <= watts;
    end
  end

  // Status back to the controller and handshake outputs.
  assign sts.needs_watts = dirty || (op_q == CMD_SET_ALL) || (op_q == CMD_SET_ONE) ||
                           (op_q == CMD_EN_ALL) || (op_q == CMD_EN_ONE);
  assign sts.last_chan   = idx == IDX_W'(CHANNELS - 1);
  assign sts.div_last    = div_cnt == '0;
  assign sts.out_free    = !out_valid || result.ready;
  assign item.ready      = cmd.in_ready;
  assign result.valid    = out_valid;

  // Internal checks.
  `TPAC_ASSERT_IMPL(a_load_free, cmd.out_load, !out_valid || result.ready, "result overwritten")
  `TPAC_ASSERT_NEXT(a_zc_clear, cmd.apply && op_q == CMD_ZERO_CROSS, phase_count == '0, "no clear")
  `TPAC_ASSERT_IMPL(a_rem_below_n, cmd.div_step && n_eff != '0, rem < n_eff, "bad remainder")

endmodule

[rtl/triac_phase_angle_controller.sv]
// Top level of the multi-channel phase-angle triac controller.
// Depends on tpac_pkg, tpac_in_if, tpac_out_if, tpac_ctrl and tpac_dp.
//
//   Channel   Dir  Handshake     Word
//   item      in   valid/ready   cmd, channel, power_req, enable_bit
//   result    out  valid/ready   gate_bits, status, channel_power, any_enabled, actual_watts
//   cfg_*     in   cfg_write     cfg_index selects register, cfg_data carries the value
//
// Tick, zero-cross and unknown commands pass the load, calc, apply and output states; the
// output state waits for a free result register. Power and enable commands, and the first
// command after a register write, also sum the channel watts (a multiply and an accumulate
// step per channel) and divide the ACC_W-bit sum, ACC_W = 16 + clog2(CHANNELS), by the
// channel count, one step per quotient bit. Reset is synchronous. A new command is accepted
// while a word waits in the result register; its own result then waits until that is taken.
`timescale 1ns / 1ps

module triac_phase_angle_controller import tpac_pkg::*; #(
  parameter int CHANNELS    = 4,
  parameter int PULSE_TICKS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tpac_in_if.sink               item,
  tpac_out_if.source            result
);

  tpac_cmd_t cmd;
  tpac_sts_t sts;

  // Sequencer.
  tpac_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Channel state and arithmetic.
  tpac_dp #(
    .CHANNELS    (CHANNELS),
    .PULSE_TICKS (PULSE_TICKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .item      (item),
    .result    (result)
  );

endmodule
